@@ hdl/binary_trie_max_xor_defines.svh @@
// Assertion helper macros for the max-xor trie block.
`ifndef BINARY_TRIE_MAX_XOR_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_DEFINES_SVH
`define BTMX_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("%m: lbl");
`define BTMX_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("%m: lbl");
`endif

@@ hdl/btmx_pkg.sv @@
package btmx_pkg;
  localparam int KEY_BITS = 32;
  localparam int NODE_CAPACITY = 4096;
  localparam int COUNT_BITS = 16;
  localparam int NODE_W = $clog2(NODE_CAPACITY);
  localparam int FREE_W = NODE_W + 1;
  localparam int LVL_W = $clog2(KEY_BITS);
  localparam int CH_W = 2 * NODE_W;
  localparam int RAM_W = CH_W + COUNT_BITS;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // node word: {child1, child0, count}
  typedef struct packed {
    logic [NODE_W-1:0]     c1;
    logic [NODE_W-1:0]     c0;
    logic [COUNT_BITS-1:0] cnt;
  } node_t;
endpackage

@@ hdl/btmx_ram.sv @@
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/binary_trie_max_xor.sv @@
// Accept to out_valid: insert/remove do a check walk, then an update walk, root..leaf
// = 33 nodes, read then eval per node (fresh node: eval only); a query does read and
// eval per level, plus an opposite-child check where one exists; empty set, full count
// or unused code go straight to out. One item at a time: in_ready is low from accept
// until the out beat is taken; it returns the cycle after. Reset: synchronous active-low
// rst_n clears the root word (flops), sets pool pointer to one; nodes written on use.
module binary_trie_max_xor
  import btmx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_best_xor,
  output logic [1:0]  out_status
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,  // read address of current node on the port
    S_EVAL = 5'b00100,  // node word valid: decide, write back in update pass
    S_QEV  = 5'b01000,  // query: word of the opposite child valid
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]  act_r;
  logic [31:0] val_r, best_r;
  logic [1:0]  stat_r;
  logic        upd_r;            // update pass of insert/remove
  logic        leaf_r;           // current node is the leaf
  logic        fresh_r;          // current node just allocated, word is all zero
  logic [LVL_W-1:0] lvl_r;
  logic [NODE_W-1:0] cur_r, oth_r, same_r;
  logic [FREE_W-1:0] free_r;
  node_t root_r;                 // node 0 lives in flops so reset can clear it

  // node memory port
  logic we;
  logic [NODE_W-1:0] waddr, raddr;
  logic [RAM_W-1:0] wdata, rdata;
  node_t rword, cur_word, upd_word;

  logic kb, alloc, cur_dead, oth_live, pool_short, quick;
  logic [NODE_W-1:0] nx, oth;
  logic [FREE_W:0] need_top;

  btmx_ram #(.WIDTH(RAM_W), .DEPTH(NODE_CAPACITY)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign rword = node_t'(rdata);
  // root from flops, fresh node reads as zero, anything else from the port
  assign cur_word = fresh_r ? '0 : ((cur_r == '0) ? root_r : rword);

  assign kb  = val_r[lvl_r];
  assign nx  = kb ? cur_word.c1 : cur_word.c0;
  assign oth = kb ? cur_word.c0 : cur_word.c1;

  // a node on the path is allocated only in the update pass of an insert
  assign alloc = (act_r == ACT_INSERT) && !leaf_r && (nx == '0);
  // query walk stops on a non-root node that no stored key passes through
  assign cur_dead = (cur_r != '0) && (cur_word.cnt == '0);
  assign oth_live = (rword.cnt != '0);

  // first missing child at bit lvl needs lvl+1 new nodes
  assign need_top   = {1'b0, free_r} + (FREE_W+1)'(lvl_r) + (FREE_W+1)'(1);
  assign pool_short = need_top > (FREE_W+1)'(NODE_CAPACITY);

  // items answered without a walk
  assign quick = (in_action == ACT_QUERY && root_r.cnt == '0) ||
                 (in_action == ACT_INSERT && root_r.cnt == COUNT_MAX) ||
                 (in_action == ACT_RSVD);

  always_comb begin
    upd_word = cur_word;
    if (act_r == ACT_INSERT) upd_word.cnt = cur_word.cnt + 1'b1;
    else upd_word.cnt = cur_word.cnt - 1'b1;
    if (alloc) begin
      if (kb) upd_word.c1 = free_r[NODE_W-1:0];
      else    upd_word.c0 = free_r[NODE_W-1:0];
    end
  end

  // EVAL puts the opposite child on the port so a query has its word in QEV
  assign raddr = (state_r == S_EVAL) ? oth : cur_r;
  assign we    = (state_r == S_EVAL) && upd_r && (cur_r != '0);
  assign waddr = cur_r;
  assign wdata = upd_word;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_best_xor = best_r;
  assign out_status   = stat_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        if (quick) state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        if (act_r == ACT_QUERY) begin
          if (cur_dead) state_nxt = S_OUT;
          else if (oth != '0) state_nxt = S_QEV;
          else if (nx == '0 || lvl_r == '0) state_nxt = S_OUT;
          else state_nxt = S_RD;
        end else if (!upd_r) begin
          // check pass
          if (leaf_r) begin
            if (act_r == ACT_REMOVE && cur_word.cnt == '0) state_nxt = S_OUT;
            else state_nxt = S_RD;
          end else if (nx == '0) begin
            if (act_r == ACT_REMOVE || pool_short) state_nxt = S_OUT;
            else state_nxt = S_RD;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          // update pass
          if (leaf_r) state_nxt = S_OUT;
          else if (alloc) state_nxt = S_EVAL;
          else state_nxt = S_RD;
        end
      end
      S_QEV: begin
        if (lvl_r == '0 || (!oth_live && same_r == '0)) state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= FREE_W'(1);
      root_r  <= '0;
      act_r   <= ACT_INSERT;
      val_r   <= '0;
      best_r  <= '0;
      stat_r  <= ST_OK;
      upd_r   <= 1'b0;
      leaf_r  <= 1'b0;
      fresh_r <= 1'b0;
      lvl_r   <= '0;
      cur_r   <= '0;
      oth_r   <= '0;
      same_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          act_r <= in_action; val_r <= in_value; best_r <= '0;
          upd_r <= 1'b0; leaf_r <= 1'b0; fresh_r <= 1'b0; cur_r <= '0;
          lvl_r <= LVL_W'(KEY_BITS - 1);
          if (in_action == ACT_QUERY && root_r.cnt == '0) stat_r <= ST_EMPTY;
          else if (in_action == ACT_INSERT && root_r.cnt == COUNT_MAX) stat_r <= ST_FULL;
          else stat_r <= ST_OK;
        end
        S_EVAL: begin
          if (act_r == ACT_QUERY) begin
            oth_r  <= oth;
            same_r <= nx;
            // no opposite child: follow the same side without a count read
            if (!cur_dead && oth == '0 && nx != '0 && lvl_r != '0) begin
              cur_r <= nx;
              lvl_r <= lvl_r - 1'b1;
            end
          end else if (!upd_r) begin
            if (leaf_r) begin
              if (act_r == ACT_REMOVE && cur_word.cnt == '0) begin
                stat_r <= ST_ABSENT;
              end else begin
                upd_r <= 1'b1; cur_r <= '0; leaf_r <= 1'b0;
                lvl_r <= LVL_W'(KEY_BITS - 1);
              end
            end else if (nx == '0) begin
              if (act_r == ACT_REMOVE) stat_r <= ST_ABSENT;
              else if (pool_short) stat_r <= ST_FULL;
              else begin
                upd_r <= 1'b1; cur_r <= '0;
                lvl_r <= LVL_W'(KEY_BITS - 1);
              end
            end else begin
              cur_r <= nx;
              if (lvl_r == '0) leaf_r <= 1'b1;
              else lvl_r <= lvl_r - 1'b1;
            end
          end else begin
            // count and new child go to memory this cycle, root to flops
            if (cur_r == '0) root_r <= upd_word;
            if (!leaf_r) begin
              if (alloc) begin
                cur_r   <= free_r[NODE_W-1:0];
                free_r  <= free_r + 1'b1;
                fresh_r <= 1'b1;
              end else begin
                cur_r <= nx;
              end
              if (lvl_r == '0) leaf_r <= 1'b1;
              else lvl_r <= lvl_r - 1'b1;
            end
          end
        end
        S_QEV: begin
          if (oth_live) begin
            best_r[lvl_r] <= 1'b1;
            cur_r <= oth_r;
          end else if (same_r != '0) begin
            cur_r <= same_r;
          end
          if (lvl_r != '0) lvl_r <= lvl_r - 1'b1;
        end
        S_RD: ;
        S_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

@@ hdl/btmx_checker.sv @@
`include "binary_trie_max_xor_defines.svh"
module btmx_checker
  import btmx_pkg::*;
(
  input logic clk, rst_n, in_valid, in_ready, out_valid, out_ready,
  input logic [1:0] out_status,
  input logic [31:0] out_best_xor
);
  `BTMX_ASSERT(a_excl, !(in_ready && out_valid))
  `BTMX_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_best_xor) && $stable(out_status))
  `BTMX_ASSERT(a_acc, in_valid && in_ready |=> !in_ready)
  `BTMX_ASSERT(a_zero, out_valid && out_status != ST_OK |-> out_best_xor == '0)
  `BTMX_ASSERT_RST(a_rst, !rst_n |=> !out_valid)
endmodule
bind binary_trie_max_xor btmx_checker u_chk (.*);

@@ bench/binary_trie_max_xor_tb.sv @@
`timescale 1ns / 100ps

module binary_trie_max_xor_tb;
  import btmx_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int N_RANDOM     = 1200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_INSERT;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_best_xor;
  logic [1:0]  out_status;

  binary_trie_max_xor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_best_xor(out_best_xor), .out_status(out_status)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
  } op_beat_t;

  typedef struct packed {
    logic [31:0] best_xor;
    logic [1:0]  status;
  } trie_resp_t;

  // Shadow trie, same pool discipline as the block.
  int unsigned shadow_kid [NODE_CAPACITY][2];
  int unsigned shadow_cnt [NODE_CAPACITY];
  int unsigned shadow_next = 1;

  op_beat_t   pending_ops[$];
  trie_resp_t expected_resps[$];
  logic [31:0] keys_in_set[$];  // for well-formed removes and near-key inserts

  int  mismatches = 0;
  bit  failed = 1'b0;
  bit  stim_done = 1'b0;
  int  cycle = 0;
  int  hold_off = 0;           // long receiver stall, counted below
  bit  did_hold = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [1:0] trie_insert(logic [31:0] v);
    int unsigned cur, nx, needed;
    int i;
    cur = 0;
    needed = 0;
    if (shadow_cnt[0] >= (1 << COUNT_BITS) - 1) return ST_FULL;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      nx = shadow_kid[cur][v[i]];
      if (nx == 0) begin
        needed = i + 1;
        break;
      end
      cur = nx;
    end
    if (shadow_next + needed > NODE_CAPACITY) return ST_FULL;
    cur = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      shadow_cnt[cur]++;
      nx = shadow_kid[cur][v[i]];
      if (nx == 0) begin
        nx = shadow_next++;
        shadow_kid[nx][0] = 0;
        shadow_kid[nx][1] = 0;
        shadow_cnt[nx] = 0;
        shadow_kid[cur][v[i]] = nx;
      end
      cur = nx;
    end
    shadow_cnt[cur]++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] trie_remove(logic [31:0] v);
    int unsigned cur;
    int i;
    cur = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      cur = shadow_kid[cur][v[i]];
      if (cur == 0) return ST_ABSENT;
    end
    if (shadow_cnt[cur] == 0) return ST_ABSENT;
    cur = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      shadow_cnt[cur]--;
      cur = shadow_kid[cur][v[i]];
    end
    shadow_cnt[cur]--;
    return ST_OK;
  endfunction

  function automatic logic [31:0] trie_best_xor(logic [31:0] v);
    int unsigned cur, other, same;
    logic [31:0] best;
    int i;
    cur = 0;
    best = '0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      other = shadow_kid[cur][~v[i]];
      same  = shadow_kid[cur][v[i]];
      if (other != 0 && shadow_cnt[other] != 0) begin
        best[i] = 1'b1;
        cur = other;
      end else if (same != 0 && shadow_cnt[same] != 0) begin
        cur = same;
      end else begin
        break;
      end
    end
    return best;
  endfunction

  function automatic trie_resp_t predict_resp(op_beat_t op);
    trie_resp_t r;
    r = '0;
    case (op.action)
      ACT_INSERT: r.status = trie_insert(op.value);
      ACT_REMOVE: r.status = trie_remove(op.value);
      ACT_QUERY: begin
        if (shadow_cnt[0] == 0) r.status = ST_EMPTY;
        else r.best_xor = trie_best_xor(op.value);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic push_op(logic [1:0] a, logic [31:0] v);
    op_beat_t op;
    op.action = a;
    op.value = v;
    pending_ops = {pending_ops, op};
  endtask

  // Stimulus: directed corners first, then random mix biased to keys in the set.
  initial begin
    logic [31:0] v;
    int k, r;
    // empty set
    push_op(ACT_QUERY, 32'h0);
    push_op(ACT_REMOVE, 32'h1234_5678);
    push_op(ACT_RSVD, 32'hFFFF_FFFF);       // unused action code
    push_op(ACT_INSERT, 32'h0);
    push_op(ACT_INSERT, 32'hFFFF_FFFF);
    push_op(ACT_QUERY, 32'h0);
    push_op(ACT_QUERY, 32'hFFFF_FFFF);
    push_op(ACT_QUERY, 32'hAAAA_5555);
    push_op(ACT_INSERT, 32'hFFFF_FFFF);     // duplicate
    push_op(ACT_REMOVE, 32'hFFFF_FFFF);
    push_op(ACT_REMOVE, 32'hFFFF_FFFF);
    push_op(ACT_REMOVE, 32'hFFFF_FFFF);     // count now zero: absent
    push_op(ACT_QUERY, 32'h0);
    push_op(ACT_REMOVE, 32'hFFFF_FFFE);     // path partly missing
    push_op(ACT_REMOVE, 32'h0);
    push_op(ACT_QUERY, 32'h8000_0000);      // empty again
    push_op(ACT_INSERT, 32'h8000_0001);
    push_op(ACT_INSERT, 32'h5555_AAAA);
    push_op(ACT_QUERY, 32'h7FFF_FFFE);
    push_op(ACT_RSVD, 32'h0);
    keys_in_set = {keys_in_set, 32'h0};
    keys_in_set = {keys_in_set, 32'h8000_0001};
    keys_in_set = {keys_in_set, 32'h5555_AAAA};
    // random part; the pool (4096 nodes) runs out after ~130 fresh keys,
    // so the pool-full path is hit often
    for (k = 0; k < N_RANDOM; k++) begin
      r = $urandom_range(0, 99);
      if (keys_in_set.size() != 0 && $urandom_range(0, 1))
        v = keys_in_set[$urandom_range(0, keys_in_set.size() - 1)];
      else
        v = $urandom();
      if (r < 40) begin
        if ($urandom_range(0, 3) == 0 && keys_in_set.size() != 0)
          v = keys_in_set[$urandom_range(0, keys_in_set.size() - 1)] ^
              (32'h1 << $urandom_range(0, 31));
        push_op(ACT_INSERT, v);
        keys_in_set = {keys_in_set, v};
      end else if (r < 65) begin
        push_op(ACT_REMOVE, v);
      end else if (r < 97) begin
        push_op(ACT_QUERY, $urandom());
      end else begin
        push_op(ACT_RSVD, v);
      end
    end
    stim_done = 1'b1;
  end

  // Reset and run control.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: offer the next op after a random gap; hold it until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_resps = {expected_resps, predict_resp({in_action, in_value})};
        in_gap <= gap_len();
        if (gap_len() == 0 && pending_ops.size() != 0) begin
          // back-to-back: keep valid high, new payload
          op_beat_t op;
          op = pending_ops.pop_front();
          in_action <= op.action;
          in_value  <= op.value;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_ops.size() != 0) begin
          op_beat_t op;
          op = pending_ops.pop_front();
          in_valid  <= 1'b1;
          in_action <= op.action;
          in_value  <= op.value;
        end
      end
    end
  end

  // Receiver stall: one long hold-off early in the random part.
  always @(posedge clk) begin
    if (rst_n && !did_hold && cycle > 3000) begin
      did_hold <= 1'b1;
      hold_off <= 2000;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: best_xor=%h status=%0d",
                     out_best_xor, out_status);
        end else begin
          trie_resp_t exp_r;
          exp_r = expected_resps.pop_front();
          if (exp_r.best_xor !== out_best_xor || exp_r.status !== out_status) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp best_xor=%h status=%0d, got best_xor=%h status=%0d",
                       exp_r.best_xor, exp_r.status, out_best_xor, out_status);
          end
        end
      end
      if (hold_off > 1) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) out_gap <= gap_len();
      end
    end
  end

  // End of run: all ops taken, nothing outstanding, then drain a while.
  initial begin
    wait (stim_done);
    @(posedge clk);
    wait (pending_ops.size() == 0 && !in_valid && expected_resps.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed && expected_resps.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
